[sv/hss_pkg.sv]
// Shared types, constants and SHA-256 round tables for the HMAC-SHA256 block.
`default_nettype none
package hss_pkg;

    // Default width of the padded length field, in bits.
    localparam int LENGTH_BITS_DEF = 64;

    // Inner and outer key pad bytes.
    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;
    localparam logic [7:0] PAD_FIRST = 8'h80;

    // Number of configuration key words.
    localparam int KEY_WORDS = 8;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITEM,
        ST_COMP,
        ST_PAD,
        ST_DIG,
        ST_OUT
    } t_state;

    // What the sequencer does once a compression finishes.
    typedef enum logic [1:0] {
        AF_IKEY,
        AF_MSG,
        AF_PAD,
        AF_OKEY
    } t_after;

    // SHA-256 initial hash value, word 0 in the top bits.
    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // SHA-256 round constant for round r.
    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate right helper.
    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

[sv/hss_core.sv]
// Iterative SHA-256 compression unit: one round per clock cycle.
`default_nettype none
module hss_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [511:0] i_block,
    input  wire logic [255:0] i_h,
    output logic              o_done,
    output logic [255:0]      o_h
);

    logic [31:0]  r_v [0:7];
    logic [31:0]  r_hin [0:7];
    logic [31:0]  r_w [0:15];
    logic [5:0]   r_rnd;
    logic         r_busy;
    logic         r_fin;
    logic         r_done;
    logic [255:0] r_hout;

    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_next;
    logic [31:0] w_s0;
    logic [31:0] w_s1;

    // Round function and message schedule.
    always_comb begin
        w_t1 = r_v[7]
             + (hss_pkg::rotr(r_v[4], 6) ^ hss_pkg::rotr(r_v[4], 11)
                ^ hss_pkg::rotr(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + hss_pkg::round_k(r_rnd) + r_w[0];
        w_t2 = (hss_pkg::rotr(r_v[0], 2) ^ hss_pkg::rotr(r_v[0], 13)
                ^ hss_pkg::rotr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_s0 = hss_pkg::rotr(r_w[1], 7) ^ hss_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1 = hss_pkg::rotr(r_w[14], 17) ^ hss_pkg::rotr(r_w[14], 19)
             ^ (r_w[14] >> 10);
        w_next = r_w[0] + w_s0 + r_w[9] + w_s1;
    end

    // Control: round counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_fin  <= 1'b0;
            r_done <= r_fin;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Working variables, schedule window and the final feed-forward add.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i]   <= i_h[255 - 32*i -: 32];
                r_hin[i] <= i_h[255 - 32*i -: 32];
            end
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511 - 32*i -: 32];
            end
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_next;
        end
        if (r_fin) begin
            for (int i = 0; i < 8; i++) begin
                r_hout[255 - 32*i -: 32] <= r_hin[i] + r_v[i];
            end
        end
    end

    assign o_done = r_done;
    assign o_h    = r_hout;

endmodule
`default_nettype wire

[sv/hmac_sha256_stream.sv]
// HMAC-SHA256 over a byte stream: top-level sequencer, block buffer and key registers.
//
// Usage: write the 64-byte key block into key words 0..7 through the write port
// while the block is idle. Message beats arrive on the input channel; a beat with
// has_byte set carries one byte, a beat with is_last set ends the message (any
// byte on it is absorbed first). A beat with neither flag is taken and ignored.
// The first beat of a message costs one key-block compression first. Every 64th
// message byte adds a compression in the single round-per-cycle SHA-256 unit,
// which sets the sustained rate. After is_last the block runs the inner padding
// (one or two compressions), the outer key block, 32 digest bytes and the outer
// padding before the first tag beat. The tag leaves as four 64-bit beats,
// index 0 first, last_word set on index 3; a stalled beat holds until taken.
// o_in_stall is high whenever the block is working or delivering the tag.
// Reset clears the hash state and key registers; the key survives a message.
`default_nettype none
module hmac_sha256_stream #(
    parameter int LENGTH_BITS = hss_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_digest_word,
    output logic [1:0]       o_word_index,
    output logic             o_last_word
);

    localparam int LW = LENGTH_BITS - 3;

    hss_pkg::t_state r_state, n_state;
    hss_pkg::t_after r_after, n_after;

    logic [63:0]   r_key [0:hss_pkg::KEY_WORDS-1];
    logic [511:0]  r_blk, n_blk;
    logic [255:0]  r_h, n_h;
    logic [255:0]  r_idig, n_idig;
    logic [5:0]    r_fill, n_fill;
    logic [LW-1:0] r_len, n_len;
    logic          r_phase, n_phase;
    logic          r_outer, n_outer;
    logic          r_first, n_first;
    logic          r_extra, n_extra;
    logic          r_start, n_start;
    logic [1:0]    r_oidx, n_oidx;
    logic [7:0]    r_byte, n_byte;
    logic          r_has, n_has;
    logic          r_last, n_last;

    logic [511:0] w_key;
    logic [63:0]  w_bits;
    logic [63:0]  w_bits_sh;
    logic [7:0]   w_pad_byte;
    logic         w_core_done;
    logic [255:0] w_core_h;
    logic         w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // Key block as one big-endian vector.
    always_comb begin
        for (int i = 0; i < hss_pkg::KEY_WORDS; i++) begin
            w_key[511 - 64*i -: 64] = r_key[i];
        end
    end

    // Length field in bits and the byte that goes into the current length slot.
    assign w_bits    = 64'(r_len) << 3;
    assign w_bits_sh = w_bits << {r_fill[2:0], 3'b000};

    always_comb begin
        if (r_first) begin
            w_pad_byte = hss_pkg::PAD_FIRST;
        end else if (!r_extra && r_fill >= 6'd56) begin
            w_pad_byte = w_bits_sh[63:56];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    // Shared compression unit.
    hss_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_block (r_blk),
        .i_h     (r_h),
        .o_done  (w_core_done),
        .o_h     (w_core_h)
    );

    // Key register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hss_pkg::KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we && i_cfg_idx[3] == 1'b0) begin
            r_key[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    // Sequencer state and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hss_pkg::ST_IDLE;
            r_after <= hss_pkg::AF_IKEY;
            r_h     <= hss_pkg::SHA_IV;
            r_fill  <= '0;
            r_len   <= '0;
            r_phase <= 1'b0;
            r_outer <= 1'b0;
            r_first <= 1'b0;
            r_extra <= 1'b0;
            r_start <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_h     <= n_h;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_phase <= n_phase;
            r_outer <= n_outer;
            r_first <= n_first;
            r_extra <= n_extra;
            r_start <= n_start;
            r_oidx  <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_idig <= n_idig;
        r_byte <= n_byte;
        r_has  <= n_has;
        r_last <= n_last;
    end

    // Next-state and datapath control.
    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_blk   = r_blk;
        n_h     = r_h;
        n_idig  = r_idig;
        n_fill  = r_fill;
        n_len   = r_len;
        n_phase = r_phase;
        n_outer = r_outer;
        n_first = r_first;
        n_extra = r_extra;
        n_start = 1'b0;
        n_oidx  = r_oidx;
        n_byte  = r_byte;
        n_has   = r_has;
        n_last  = r_last;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;

        case (r_state)
            hss_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (w_in_acc && (i_has_byte || i_is_last)) begin
                    n_byte = i_data_byte;
                    n_has  = i_has_byte;
                    n_last = i_is_last;
                    if (!r_phase) begin
                        // Start the inner pass with the key block.
                        n_phase = 1'b1;
                        n_outer = 1'b0;
                        n_h     = hss_pkg::SHA_IV;
                        n_blk   = w_key ^ {64{hss_pkg::IPAD}};
                        n_fill  = '0;
                        n_len   = LW'(64);
                        n_after = hss_pkg::AF_IKEY;
                        n_start = 1'b1;
                        n_state = hss_pkg::ST_COMP;
                    end else begin
                        n_state = hss_pkg::ST_ITEM;
                    end
                end
            end

            hss_pkg::ST_ITEM: begin
                if (r_has) begin
                    n_blk  = {r_blk[503:0], r_byte};
                    n_fill = r_fill + 6'd1;
                    n_len  = r_len + LW'(1);
                end
                if (r_has && r_fill == 6'd63) begin
                    n_after = hss_pkg::AF_MSG;
                    n_start = 1'b1;
                    n_state = hss_pkg::ST_COMP;
                end else if (r_last) begin
                    n_first = 1'b1;
                    n_extra = 1'b0;
                    n_state = hss_pkg::ST_PAD;
                end else begin
                    n_state = hss_pkg::ST_IDLE;
                end
            end

            hss_pkg::ST_COMP: begin
                if (w_core_done) begin
                    n_h = w_core_h;
                    case (r_after)
                        hss_pkg::AF_IKEY: begin
                            n_state = hss_pkg::ST_ITEM;
                        end
                        hss_pkg::AF_MSG: begin
                            if (r_last) begin
                                n_first = 1'b1;
                                n_extra = 1'b0;
                                n_state = hss_pkg::ST_PAD;
                            end else begin
                                n_state = hss_pkg::ST_IDLE;
                            end
                        end
                        hss_pkg::AF_PAD: begin
                            if (r_extra) begin
                                n_extra = 1'b0;
                                n_state = hss_pkg::ST_PAD;
                            end else if (r_outer) begin
                                n_oidx  = '0;
                                n_state = hss_pkg::ST_OUT;
                            end else begin
                                // Inner digest done: start the outer pass.
                                n_idig  = w_core_h;
                                n_h     = hss_pkg::SHA_IV;
                                n_blk   = w_key ^ {64{hss_pkg::OPAD}};
                                n_fill  = '0;
                                n_len   = LW'(64);
                                n_outer = 1'b1;
                                n_after = hss_pkg::AF_OKEY;
                                n_start = 1'b1;
                                n_state = hss_pkg::ST_COMP;
                            end
                        end
                        hss_pkg::AF_OKEY: begin
                            n_state = hss_pkg::ST_DIG;
                        end
                        default: begin
                            n_state = hss_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            hss_pkg::ST_PAD: begin
                // Append one padding byte a cycle.
                n_blk   = {r_blk[503:0], w_pad_byte};
                n_fill  = r_fill + 6'd1;
                n_first = 1'b0;
                if (r_first && r_fill >= 6'd56) begin
                    n_extra = 1'b1;
                end
                if (r_fill == 6'd63) begin
                    n_after = hss_pkg::AF_PAD;
                    n_start = 1'b1;
                    n_state = hss_pkg::ST_COMP;
                end
            end

            hss_pkg::ST_DIG: begin
                // Feed the inner digest into the outer pass, one byte a cycle.
                n_blk  = {r_blk[503:0], r_idig[255:248]};
                n_idig = {r_idig[247:0], 8'h00};
                n_fill = r_fill + 6'd1;
                n_len  = r_len + LW'(1);
                if (r_fill == 6'd31) begin
                    n_first = 1'b1;
                    n_extra = 1'b0;
                    n_state = hss_pkg::ST_PAD;
                end
            end

            hss_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_h    = {r_h[191:0], 64'h0};
                    n_oidx = r_oidx + 2'd1;
                    if (r_oidx == 2'd3) begin
                        n_h     = hss_pkg::SHA_IV;
                        n_fill  = '0;
                        n_len   = '0;
                        n_phase = 1'b0;
                        n_outer = 1'b0;
                        n_state = hss_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = hss_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_digest_word = r_h[255:192];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 2'd3);

endmodule
`default_nettype wire
